@@ sv/ccs_pkg.sv @@
// shared constants and types for the chaikin curve subdivider
package ccs_pkg;

  localparam int MAX_PASSES  = 4;
  localparam int COORD_WIDTH = 16;
  localparam int NUM_AXES    = 3;
  localparam int NUM_SLOTS   = 4;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int PASS_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PASSES = CFG_IDX_W'(1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef coord_t [NUM_AXES-1:0] point_t;

  typedef struct packed {
    point_t pt;
    logic   fin;
  } vertex_t;

  typedef struct packed {
    logic bypass;
    logic closed;
    logic clear;
  } stage_ctrl_t;

endpackage

@@ sv/ccs_in_if.sv @@
// control point channel
interface ccs_in_if import ccs_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  logic   final_point;

  modport source (output valid, pos_x, pos_y, pos_z, final_point, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, final_point, output ready);
endinterface

@@ sv/ccs_out_if.sv @@
// subdivided vertex channel
interface ccs_out_if import ccs_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   curve_end;

  modport source (output valid, out_x, out_y, out_z, curve_end, input ready);
  modport sink (input valid, out_x, out_y, out_z, curve_end, output ready);
endinterface

@@ sv/ccs_lane.sv @@
// one coordinate lane: both corner cuts for the open segment and the closing segment
module ccs_lane import ccs_pkg::*; (
  input  coord_t prev,
  input  coord_t cur,
  input  coord_t first,
  output coord_t cut_a,
  output coord_t cut_b,
  output coord_t close_a,
  output coord_t close_b
);

  localparam int SUM_W = COORD_WIDTH + 2;

  logic signed [SUM_W-1:0] prev_e, cur_e, first_e;
  logic signed [SUM_W-1:0] sum_a, sum_b, sum_c, sum_d;

  assign prev_e  = SUM_W'(prev);
  assign cur_e   = SUM_W'(cur);
  assign first_e = SUM_W'(first);

  // 3p+q and p+3q, floor of quarter taken by dropping two low bits
  assign sum_a = (prev_e <<< 1) + prev_e + cur_e;
  assign sum_b = prev_e + (cur_e <<< 1) + cur_e;
  assign sum_c = (cur_e <<< 1) + cur_e + first_e;
  assign sum_d = cur_e + (first_e <<< 1) + first_e;

  assign cut_a   = sum_a[SUM_W-1:2];
  assign cut_b   = sum_b[SUM_W-1:2];
  assign close_a = sum_c[SUM_W-1:2];
  assign close_b = sum_d[SUM_W-1:2];

endmodule

@@ sv/ccs_stage.sv @@
// one chaikin pass: per-axis lanes, merged into up to four queued vertices
module ccs_stage import ccs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  stage_ctrl_t ctrl,
  input  logic        in_valid,
  output logic        in_ready,
  input  vertex_t     in_vtx,
  output logic        out_valid,
  input  logic        out_ready,
  output vertex_t     out_vtx,
  output logic        started
);

  logic                 started_r, started_nxt;
  point_t               first_r, prev_r;
  vertex_t              slot_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] mask_r, mask_nxt, mask_new;
  logic [SLOT_W-1:0]    sel;
  logic                 last, take;
  point_t               first_eff, cut_a, cut_b, close_a, close_b;

  assign first_eff = started_r ? first_r : in_vtx.pt;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    ccs_lane u_lane (
      .prev    (prev_r[g]),
      .cur     (in_vtx.pt[g]),
      .first   (first_eff[g]),
      .cut_a   (cut_a[g]),
      .cut_b   (cut_b[g]),
      .close_a (close_a[g]),
      .close_b (close_b[g])
    );
  end

  // lowest pending slot goes out first
  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) sel = SLOT_W'(i);
    end
  end

  assign last      = (mask_r & (mask_r - 1'b1)) == '0;
  assign out_valid = |mask_r;
  assign out_vtx   = slot_r[sel];
  assign in_ready  = !(|mask_r) || (last && out_ready);
  assign take      = in_valid && in_ready;
  assign started   = started_r;

  always_comb begin
    if (ctrl.bypass) begin
      mask_new = NUM_SLOTS'(1);
    end else begin
      mask_new[0] = started_r || !ctrl.closed;
      mask_new[1] = started_r;
      mask_new[2] = in_vtx.fin;
      mask_new[3] = in_vtx.fin && ctrl.closed;
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (take) begin
      mask_nxt = mask_new;
    end else if (out_valid && out_ready) begin
      mask_nxt = mask_r & (mask_r - 1'b1);
    end
  end

  always_comb begin
    started_nxt = started_r;
    if (take && !ctrl.bypass) started_nxt = !in_vtx.fin;
    if (ctrl.clear) started_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= '0;
      started_r <= 1'b0;
    end else begin
      mask_r    <= mask_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (ctrl.bypass) begin
        slot_r[0] <= in_vtx;
      end else begin
        slot_r[0] <= '{pt: started_r ? cut_a : in_vtx.pt, fin: 1'b0};
        slot_r[1] <= '{pt: cut_b, fin: 1'b0};
        slot_r[2] <= ctrl.closed ? vertex_t'{pt: close_a, fin: 1'b0}
                                 : vertex_t'{pt: in_vtx.pt, fin: 1'b1};
        slot_r[3] <= '{pt: close_b, fin: 1'b1};
        prev_r    <= in_vtx.pt;
        if (!started_r) first_r <= in_vtx.pt;
      end
    end
  end

endmodule

@@ sv/chaikin_curve_subdivider.sv @@
// Chaikin corner-cutting subdivider: a cascade of MAX_PASSES stages, each cutting x, y and z in
// three parallel lanes; stages beyond pass_count forward points unchanged. A stage emits at most
// four vertices from each point, one vertex per cycle while the next stage takes them, and takes
// a new point only when empty or as its last vertex leaves. Each stage registers the vertices it
// emits, and an output register follows the cascade and passes one vertex per cycle while the
// result channel is ready. Write configuration only while the block is idle; any valid register
// write abandons a curve in progress.
module chaikin_curve_subdivider import ccs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ccs_in_if.sink                in_pts,
  ccs_out_if.source             out_vtx
);

  logic              closed_r;
  logic [PASS_W-1:0] passes_r;
  logic [PASS_W-1:0] active_passes;
  logic              cfg_hit;

  logic              ch_valid [MAX_PASSES+1];
  logic              ch_ready [MAX_PASSES+1];
  vertex_t           ch_vtx   [MAX_PASSES+1];
  logic              stage_started [MAX_PASSES];
  stage_ctrl_t       stage_ctrl    [MAX_PASSES];

  logic              out_valid_r;
  vertex_t           out_vtx_r;

  assign cfg_hit = cfg_we && (cfg_index == CFG_CLOSED || cfg_index == CFG_PASSES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r <= 1'b0;
      passes_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLOSED: closed_r <= cfg_data[0];
        CFG_PASSES: passes_r <= cfg_data[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  assign active_passes = (passes_r > PASS_W'(MAX_PASSES)) ? PASS_W'(MAX_PASSES) : passes_r;

  assign ch_valid[0]  = in_pts.valid;
  assign ch_vtx[0].pt = {in_pts.pos_z, in_pts.pos_y, in_pts.pos_x};
  assign ch_vtx[0].fin = in_pts.final_point;
  assign in_pts.ready = ch_ready[0];

  for (genvar s = 0; s < MAX_PASSES; s++) begin : g_stage
    assign stage_ctrl[s] = '{bypass: PASS_W'(s) >= active_passes, closed: closed_r,
                             clear: cfg_hit};
    ccs_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (stage_ctrl[s]),
      .in_valid  (ch_valid[s]),
      .in_ready  (ch_ready[s]),
      .in_vtx    (ch_vtx[s]),
      .out_valid (ch_valid[s+1]),
      .out_ready (ch_ready[s+1]),
      .out_vtx   (ch_vtx[s+1]),
      .started   (stage_started[s])
    );
  end

  // output register parts the cascade from the result channel
  assign ch_ready[MAX_PASSES] = !out_valid_r || out_vtx.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ch_ready[MAX_PASSES]) begin
      out_valid_r <= ch_valid[MAX_PASSES];
    end
  end

  always_ff @(posedge clk) begin
    if (ch_ready[MAX_PASSES] && ch_valid[MAX_PASSES]) out_vtx_r <= ch_vtx[MAX_PASSES];
  end

  assign out_vtx.valid     = out_valid_r;
  assign out_vtx.out_x     = out_vtx_r.pt[0];
  assign out_vtx.out_y     = out_vtx_r.pt[1];
  assign out_vtx.out_z     = out_vtx_r.pt[2];
  assign out_vtx.curve_end = out_vtx_r.fin;

  // a register write abandons any curve in progress
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> !stage_started[0] && !stage_started[MAX_PASSES-1])
    else $error("curve state survived a configuration write");

  // a stage outside the active pass count never holds curve state
  for (genvar s = 0; s < MAX_PASSES; s++) begin : g_chk
    a_bypass_idle: assert property (@(posedge clk) disable iff (!rst_n)
      stage_started[s] |-> !stage_ctrl[s].bypass)
      else $error("bypassed stage has a curve in progress");
  end

endmodule
